### rtl/tks_pkg.sv
package tks_pkg;

  // Default table size
  localparam int unsigned DEF_TABLE_DEPTH = 256;

  // Fixed field widths
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned EIDX_W    = 8;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;

  // Item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Search methods
  localparam logic METHOD_SEQ = 1'b0;
  localparam logic METHOD_BIN = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_METHOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH  = 2'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FINISH
  } tks_state_t;

endpackage

### rtl/tks_mem.sv
module tks_mem
  import tks_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
  input  logic signed [KEY_W-1:0]               wr_data,
  input  logic                                  rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
  output logic signed [KEY_W-1:0]               rd_data
);

  logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tks_ctrl.sv
module tks_ctrl
  import tks_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [EIDX_W-1:0]                     in_entry_index,
  input  logic signed [KEY_W-1:0]               in_entry_value,
  input  logic signed [KEY_W-1:0]               in_search_key,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic [EIDX_W-1:0]                     out_match_index,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DAT_W-1:0]                  cfg_data,
  // table memory
  output logic                                  mem_wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]        mem_wr_addr,
  output logic signed [KEY_W-1:0]               mem_wr_data,
  output logic                                  mem_rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]        mem_rd_addr,
  input  logic signed [KEY_W-1:0]               mem_rd_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  tks_state_t state_r, state_nxt;

  logic                    method_r;
  logic [LEN_W-1:0]        length_r;
  logic [LEN_W-1:0]        used_len;

  logic                    s_method_r, s_method_nxt;
  logic [LEN_W-1:0]        n_r, n_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0]        lo_r, lo_nxt;
  logic [LEN_W-1:0]        hi_r, hi_nxt;
  logic [LEN_W-1:0]        idx_r, idx_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [EIDX_W-1:0]       res_idx_r, res_idx_nxt;

  logic                    out_valid_r;
  logic                    out_found_r;
  logic [EIDX_W-1:0]       out_idx_r;

  logic                    out_free;
  logic                    hit;
  logic                    key_less;
  logic                    scan_done;
  logic [LEN_W-1:0]        rd_idx;
  logic [LEN_W-1:0]        next_seq;
  logic [LEN_W-1:0]        mid_left;
  logic [LEN_W-1:0]        mid_right;
  logic [LEN_W-1:0]        mid_first;
  logic [LEN_W:0]          sum_left;
  logic [LEN_W:0]          sum_right;
  logic [LEN_W:0]          sum_first;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= METHOD_SEQ;
      length_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEARCH_METHOD: method_r <= cfg_data[0];
        CFG_TABLE_LENGTH:  length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the length at the table depth
  always_comb begin
    used_len = length_r;
    if (32'(length_r) > TABLE_DEPTH) begin
      used_len = LEN_W'(TABLE_DEPTH);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Compare the returned word against the key
  assign hit      = (mem_rd_data == key_r);
  assign key_less = (key_r < mem_rd_data);
  assign next_seq = idx_r + 1'b1;

  // Midpoints of the shrunk window, rounded down
  assign sum_left  = {1'b0, lo_r} + {1'b0, idx_r} - 1'b1;
  assign sum_right = {1'b0, idx_r} + 1'b1 + {1'b0, hi_r};
  assign sum_first = {1'b0, n_r} - 1'b1;
  assign mid_left  = sum_left[LEN_W:1];
  assign mid_right = sum_right[LEN_W:1];
  assign mid_first = sum_first[LEN_W:1];

  // End of search: hit, or the window or scan ran out
  always_comb begin
    scan_done = hit;
    if (!hit) begin
      if (s_method_r == METHOD_SEQ) begin
        scan_done = (next_seq == n_r);
      end else if (key_less) begin
        scan_done = (idx_r == lo_r);
      end else begin
        scan_done = (idx_r == hi_r);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_SEARCH) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = (n_r == '0) ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    s_method_nxt  = s_method_r;
    n_nxt         = n_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    rd_idx        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_WRITE) begin
            mem_wr_en = (32'(in_entry_index) < TABLE_DEPTH);
          end else begin
            s_method_nxt = method_r;
            n_nxt        = used_len;
            key_nxt      = in_search_key;
          end
        end
      end
      ST_START: begin
        lo_nxt        = '0;
        hi_nxt        = n_r - 1'b1;
        res_found_nxt = 1'b0;
        res_idx_nxt   = '0;
        if (n_r != '0) begin
          rd_idx    = (s_method_r == METHOD_BIN) ? mid_first : '0;
          mem_rd_en = 1'b1;
          idx_nxt   = rd_idx;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = idx_r[EIDX_W-1:0];
        end else if (!scan_done) begin
          if (s_method_r == METHOD_SEQ) begin
            rd_idx = next_seq;
          end else if (key_less) begin
            hi_nxt = idx_r - 1'b1;
            rd_idx = mid_left;
          end else begin
            lo_nxt = next_seq;
            rd_idx = mid_right;
          end
          mem_rd_en = 1'b1;
          idx_nxt   = rd_idx;
        end
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  assign mem_wr_addr = AW'(in_entry_index);
  assign mem_wr_data = in_entry_value;
  assign mem_rd_addr = AW'(rd_idx);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) begin
        out_valid_r <= (state_r == ST_FINISH);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s_method_r  <= s_method_nxt;
    n_r         <= n_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    idx_r       <= idx_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    if (out_free && state_r == ST_FINISH) begin
      out_found_r <= res_found_r;
      out_idx_r   <= res_idx_r;
    end
  end

  // Port outputs
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    out_valid       = out_valid_r;
    out_found       = out_found_r;
    out_match_index = out_idx_r;
  end

endmodule

### rtl/table_key_search_top.sv
// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+------------------------------------------
// in_       | input     | in_valid/in_stall  | kind, entry_index, entry_value, search_key
// out_      | output    | out_valid/out_stall| found, match_index
// cfg_      | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A write word goes to the table when taken. A search runs the start, scan and
// finish states; the single read port gives one probe a cycle, so a sequential
// search reads up to used length entries and a binary one about log2(length).
// Reset clears the sequencer, the output valid flag and the configuration; the
// table is undefined until written. Input is held off while a search runs, and a
// finished result waits for a stalled output before the next word is taken.
module table_key_search_top
  import tks_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_kind,
  input  logic [EIDX_W-1:0]       in_entry_index,
  input  logic signed [KEY_W-1:0] in_entry_value,
  input  logic signed [KEY_W-1:0] in_search_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [EIDX_W-1:0]       out_match_index,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                    mem_wr_en;
  logic [AW-1:0]           mem_wr_addr;
  logic signed [KEY_W-1:0] mem_wr_data;
  logic                    mem_rd_en;
  logic [AW-1:0]           mem_rd_addr;
  logic signed [KEY_W-1:0] mem_rd_data;

  // Search sequencer
  tks_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_search_key   (in_search_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data)
  );

  // Table storage
  tks_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tks_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam int          TARGET_ITEMS = 1600;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          END_CYCLES   = 40;
  localparam longint      LIMIT_NS     = 48_000_000;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  typedef enum logic [1:0] {
    PLAN_WORD,
    PLAN_CFG,
    PLAN_HOLD
  } plan_kind_t;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  typedef struct {
    plan_kind_t              what;
    logic                    kind;
    logic [EIDX_W-1:0]       eidx;
    logic signed [KEY_W-1:0] evalue;
    logic signed [KEY_W-1:0] key;
    logic [CFG_IDX_W-1:0]    cidx;
    logic [CFG_DAT_W-1:0]    cdata;
  } plan_step_t;

  typedef struct packed {
    logic              found;
    logic [EIDX_W-1:0] pos;
  } answer_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_kind = KIND_WRITE;
  logic [EIDX_W-1:0]       in_entry_index = '0;
  logic signed [KEY_W-1:0] in_entry_value = '0;
  logic signed [KEY_W-1:0] in_search_key = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_found;
  logic [EIDX_W-1:0]       out_match_index;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DAT_W-1:0]    cfg_data = '0;

  // Stimulus plan and its view of the table contents
  plan_step_t              plan_q[$];
  logic signed [KEY_W-1:0] plan_tbl[TABLE_DEPTH];
  int                      n_items = 0;

  // Search predictor state
  logic signed [KEY_W-1:0] mirror_words[TABLE_DEPTH];
  logic                    mirror_method = METHOD_SEQ;
  logic [LEN_W-1:0]        mirror_len = '0;
  answer_t                 answers_q[$];

  logic in_took = 1'b0;
  logic cfg_took = 1'b0;
  logic stim_done = 1'b0;
  int   mismatches = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   quiet = 0;
  int   win_left = 0;
  rx_mode_t rx_mode = RX_FLOW;

  table_key_search_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_search_key   (in_search_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Expected answer for a key against the mirrored table and setup
  function automatic answer_t lookup_key(logic signed [KEY_W-1:0] key);
    answer_t a;
    int      n;
    int      lo;
    int      hi;
    int      mid;
    a.found = 1'b0;
    a.pos   = '0;
    n = (mirror_len > TABLE_DEPTH) ? TABLE_DEPTH : mirror_len;
    if (mirror_method == METHOD_SEQ) begin
      for (int i = 0; i < n; i++) begin
        if (mirror_words[i] == key) begin
          a.found = 1'b1;
          a.pos   = i[EIDX_W-1:0];
          return a;
        end
      end
    end else begin
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (mirror_words[mid] == key) begin
          a.found = 1'b1;
          a.pos   = mid[EIDX_W-1:0];
          return a;
        end
        if (key < mirror_words[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
    end
    return a;
  endfunction

  task automatic push_write(logic [EIDX_W-1:0] idx, logic signed [KEY_W-1:0] val);
    plan_step_t s;
    s.what   = PLAN_WORD;
    s.kind   = KIND_WRITE;
    s.eidx   = idx;
    s.evalue = val;
    s.key    = $urandom;
    s.cidx   = '0;
    s.cdata  = '0;
    plan_q.push_back(s);
    plan_tbl[idx] = val;
    n_items++;
  endtask

  task automatic push_search(logic signed [KEY_W-1:0] key);
    plan_step_t s;
    s.what   = PLAN_WORD;
    s.kind   = KIND_SEARCH;
    s.eidx   = EIDX_W'($urandom);
    s.evalue = $urandom;
    s.key    = key;
    s.cidx   = '0;
    s.cdata  = '0;
    plan_q.push_back(s);
    n_items++;
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    plan_step_t s;
    s.what   = PLAN_CFG;
    s.kind   = KIND_WRITE;
    s.eidx   = '0;
    s.evalue = '0;
    s.key    = '0;
    s.cidx   = idx;
    s.cdata  = data;
    plan_q.push_back(s);
  endtask

  task automatic push_hold();
    plan_step_t s;
    s.what   = PLAN_HOLD;
    s.kind   = KIND_WRITE;
    s.eidx   = '0;
    s.evalue = '0;
    s.key    = '0;
    s.cidx   = '0;
    s.cdata  = '0;
    plan_q.push_back(s);
  endtask

  // Load entries 0..n-1 with non-decreasing values, tight steps or spread wide
  task automatic fill_sorted(int n);
    longint span;
    longint v;
    if ($urandom_range(0, 1) == 0) span = 3;
    else span = 64'sd4294967295 / n;
    v = -64'sd2147483648 + (longint'($urandom) % (64'sd4294967296 - span * n));
    for (int i = 0; i < n; i++) begin
      push_write(i[EIDX_W-1:0], v[31:0]);
      v += longint'($urandom) % (span + 1);
    end
  endtask

  // Main sequence: build the plan, reset, wait for the block to drain
  initial begin : main
    int                      phase;
    int                      r;
    int                      len;
    int                      used;
    int                      nsearch;
    int                      nwrite;
    int                      j;
    logic                    meth;
    logic                    ordered;
    logic [CFG_DAT_W-1:0]    d;
    logic signed [KEY_W-1:0] pool[4];
    logic signed [KEY_W-1:0] k;

    // Empty table in both methods
    push_search(32'sd0);
    push_search(KEY_MIN);
    push_cfg(CFG_SEARCH_METHOD, {8'd0, METHOD_BIN});
    push_search(KEY_MAX);

    // Ascending table spanning the whole key range
    fill_sorted(TABLE_DEPTH);
    push_write(8'd0, KEY_MIN);
    push_write(8'd255, KEY_MAX);
    push_cfg(CFG_TABLE_LENGTH, 9'd256);
    push_search(KEY_MIN);
    push_search(KEY_MAX);
    push_search(plan_tbl[127]);
    push_search(plan_tbl[200] + 1);
    push_search(plan_tbl[3]);

    // Length past the depth saturates
    push_cfg(CFG_TABLE_LENGTH, 9'h1FF);
    push_search(KEY_MAX);
    push_search(plan_tbl[64]);

    // Full sequential scan
    push_cfg(CFG_SEARCH_METHOD, {8'd0, METHOD_SEQ});
    push_search(KEY_MAX);
    push_search(KEY_MIN);
    push_search(plan_tbl[128] - 1);

    // Spare register indexes must leave the setup alone
    push_cfg(CFG_IDX_SPARE2, 9'h1FF);
    push_cfg(CFG_IDX_SPARE3, 9'h000);
    push_search(plan_tbl[77]);

    // Descending table under binary search
    push_cfg(CFG_SEARCH_METHOD, {8'd0, METHOD_BIN});
    push_cfg(CFG_TABLE_LENGTH, 9'd8);
    for (int i = 0; i < 8; i++) push_write(i[EIDX_W-1:0], 32'sd100 - 32'sd10 * i);
    push_search(32'sd100);
    push_search(32'sd70);
    push_search(32'sd30);

    // Random phases, each with its own method, length and table contents
    phase = 0;
    while (n_items < TARGET_ITEMS) begin
      r    = $urandom_range(0, 31);
      meth = 1'($urandom_range(0, 1));
      if (r == 0) len = 0;
      else if (r == 1) len = 256;
      else if (r == 2) len = $urandom_range(257, 511);
      else len = $urandom_range(1, 24);
      if (phase == 0) begin
        meth = METHOD_SEQ;
        len  = 24;
      end
      used    = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      ordered = (meth == METHOD_BIN) && ($urandom_range(0, 7) != 0);
      for (int i = 0; i < 4; i++) pool[i] = $urandom;

      d    = CFG_DAT_W'($urandom);
      d[0] = meth;
      push_cfg(CFG_SEARCH_METHOD, d);
      push_cfg(CFG_TABLE_LENGTH, len[CFG_DAT_W-1:0]);

      if (ordered && used > 0) begin
        fill_sorted(used);
      end else if (used > 0) begin
        nwrite = $urandom_range(0, (used > 24) ? 24 : used);
        for (int i = 0; i < nwrite; i++) begin
          j = $urandom_range(0, used - 1);
          if ($urandom_range(0, 2) == 0) k = $urandom;
          else k = pool[$urandom_range(0, 3)];
          push_write(j[EIDX_W-1:0], k);
        end
      end

      if (phase == 0) push_hold();
      nsearch = (phase == 0) ? 30 : $urandom_range(6, 20);
      for (int i = 0; i < nsearch; i++) begin
        // stray writes between searches, only where order does not matter
        if (!ordered && $urandom_range(0, 9) == 0) begin
          j = $urandom_range(0, TABLE_DEPTH - 1);
          push_write(j[EIDX_W-1:0], pool[$urandom_range(0, 3)]);
        end
        r = $urandom_range(0, 9);
        if (used > 0 && r < 6) k = plan_tbl[$urandom_range(0, used - 1)];
        else if (used > 0 && r < 8) k = plan_tbl[$urandom_range(0, used - 1)] + (r == 6 ? 1 : -1);
        else k = $urandom;
        push_search(k);
      end
      phase++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!stim_done || answers_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && answers_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Sender: offer words in bursts, drain the block before each register write
  always @(negedge clk) begin : feed
    plan_step_t s;
    logic       in_busy;
    logic       cfg_busy;
    logic       fire_in;
    logic       fire_cfg;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      stim_done <= 1'b0;
    end else begin
      in_busy  = in_valid && !in_took;
      cfg_busy = cfg_valid && !cfg_took;
      fire_in  = 1'b0;
      fire_cfg = 1'b0;
      if (!in_busy && !cfg_busy && plan_q.size() != 0) begin
        s = plan_q[0];
        case (s.what)
          PLAN_HOLD: begin
            hold_req <= hold_req + 1;
            void'(plan_q.pop_front());
          end
          PLAN_CFG: begin
            if (answers_q.size() != 0) begin
              quiet = 0;
            end else if (quiet < DRAIN_CYCLES) begin
              quiet++;
            end else begin
              quiet    = 0;
              fire_cfg = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          default: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              fire_in = 1'b1;
              void'(plan_q.pop_front());
              if (burst_left <= 1) begin
                burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 10);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
              end else begin
                burst_left--;
              end
            end
          end
        endcase
      end
      if (fire_in) begin
        in_kind        <= s.kind;
        in_entry_index <= s.eidx;
        in_entry_value <= s.evalue;
        in_search_key  <= s.key;
      end
      if (fire_cfg) begin
        cfg_index <= s.cidx;
        cfg_data  <= s.cdata;
      end
      in_valid  <= in_busy || fire_in;
      cfg_valid <= cfg_busy || fire_cfg;
      stim_done <= (plan_q.size() == 0) && !(in_busy || fire_in) && !(cfg_busy || fire_cfg);
    end
  end

  // Receiver: stall in windows of varying density, or hold off for a long stretch
  always @(negedge clk) begin : sink
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (win_left == 0) begin
        win_left = $urandom_range(16, 96);
        rx_mode  = rx_mode_t'($urandom_range(0, 2));
      end
      win_left--;
      case (rx_mode)
        RX_FLOW:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:  out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: track handshakes, update the predictor, check each result word
  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      in_took  <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      cfg_took <= cfg_valid && cfg_ready;

      if (out_valid && !out_stall) begin
        got.found = out_found;
        got.pos   = out_match_index;
        if (answers_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: found=%0b index=%0d", got.found, got.pos);
          mismatches++;
        end else begin
          want = answers_q.pop_front();
          if (got.found !== want.found || got.pos !== want.pos) begin
            if (mismatches < 10)
              $display("mismatch: found exp %0b got %0b, index exp %0d got %0d",
                       want.found, got.found, want.pos, got.pos);
            mismatches++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEARCH_METHOD: mirror_method = cfg_data[0];
          CFG_TABLE_LENGTH:  mirror_len = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_kind == KIND_WRITE) mirror_words[in_entry_index] = in_entry_value;
        else answers_q.push_back(lookup_key(in_search_key));
      end
    end
  end

endmodule
